@@ hdl/arc_pkg.sv @@
`timescale 1ns / 1ps

package arc_pkg;

  // ASCII codes
  localparam logic [7:0] CH_B    = 8'h42;
  localparam logic [7:0] CH_D    = 8'h44;
  localparam logic [7:0] CH_H    = 8'h48;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_ONE  = 8'h31;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_LC_A = 8'h61;
  localparam logic [7:0] CH_LC_F = 8'h66;
  localparam logic [7:0] CH_UC_A = 8'h41;
  localparam logic [7:0] CH_UC_F = 8'h46;

  typedef logic [1:0] radix_t;
  localparam radix_t RADIX_BIN = 2'd0;
  localparam radix_t RADIX_DEC = 2'd1;
  localparam radix_t RADIX_HEX = 2'd2;

  localparam logic [4:0] DEC_DIVISOR = 5'd10;
  // floor(x / 10) == (x * DEC_RECIP) >> DEC_SHIFT for every 12-bit x
  localparam logic [11:0] DEC_RECIP = 12'd3277;
  localparam int          DEC_SHIFT = 15;

  // most output characters per number
  localparam int MAX_OUT = 32;
  localparam int IDX_W   = $clog2(MAX_OUT);

  typedef logic [1:0] state_t;
  localparam state_t ST_IDLE  = 2'd0;
  localparam state_t ST_DIV   = 2'd1;
  localparam state_t ST_EMIT  = 2'd2;
  localparam state_t ST_FETCH = 2'd3;

  function automatic logic letter_ok(input logic [7:0] s);
    return (s == CH_B) || (s == CH_D) || (s == CH_H);
  endfunction

  function automatic radix_t to_radix(input logic [7:0] s);
    radix_t r;
    if (s == CH_B) begin
      r = RADIX_BIN;
    end else if (s == CH_D) begin
      r = RADIX_DEC;
    end else begin
      r = RADIX_HEX;
    end
    return r;
  endfunction

  // lowercase hex digit
  function automatic logic [7:0] digit_ascii(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'b0, d};
    end else begin
      c = CH_LC_A + {4'b0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

@@ hdl/arc_div_unit.sv @@
`timescale 1ns / 1ps

// Divides by the output radix. Powers of two are a single registered shift;
// decimal is a long division one byte per step (reciprocal multiply on
// remainder:byte), ceil(VALUE_WIDTH/8) steps, done raised with the last step.
module arc_div_unit import arc_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  radix_t                 radix,
  input  logic [VALUE_WIDTH-1:0] dividend,
  output logic                   busy,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] quo,
  output logic [3:0]             rem
);

  // dividend padded up to whole bytes
  localparam int STEPS = (VALUE_WIDTH + 7) / 8;
  localparam int PAD_W = STEPS * 8;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [PAD_W-1:0] work;
  logic [CNT_W-1:0] cnt;
  logic [11:0]      chunk_val;
  logic [23:0]      prod;
  logic [7:0]       q_chunk;
  logic [11:0]      q_times10;

  assign quo       = work[VALUE_WIDTH-1:0];
  assign chunk_val = {rem, work[PAD_W-1 -: 8]};
  assign prod      = chunk_val * DEC_RECIP;
  assign q_chunk   = 8'(prod >> DEC_SHIFT);
  assign q_times10 = {4'b0, q_chunk} * {7'b0, DEC_DIVISOR};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        case (radix)
          RADIX_BIN: begin
            work <= PAD_W'(dividend >> 1);
            rem  <= {3'b0, dividend[0]};
            done <= 1'b1;
          end
          RADIX_HEX: begin
            work <= PAD_W'(dividend >> 4);
            rem  <= dividend[3:0];
            done <= 1'b1;
          end
          default: begin
            work <= PAD_W'(dividend);
            rem  <= '0;
            cnt  <= CNT_W'(STEPS);
            busy <= 1'b1;
          end
        endcase
      end else if (busy) begin
        // quotient bytes shift in at the bottom as dividend bytes leave the top
        work <= (work << 8) | PAD_W'(q_chunk);
        rem  <= 4'(chunk_val - q_times10);
        cnt  <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hdl/arc_digit_buf.sv @@
`timescale 1ns / 1ps

// Simple dual-port RAM with registered read.
module arc_digit_buf #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hdl/ascii_radix_converter.sv @@
`timescale 1ns / 1ps

// ASCII number converter between binary, decimal and hex. Characters are taken
// one per cycle while in_stall is low; a character whose two system letters
// match is echoed at once. After the last character of a number the input
// stalls while the value is taken apart by the shared divider, digits least
// significant first: binary and hex digits come from a single shift each,
// decimal digits from a byte-wise long division. A fetch state then reads the
// leading digit from the digit buffer, and each character leaves at one per
// cycle through the output register, longer only while out_stall holds it. At
// most 32 characters are produced per number (the 32 low digits if more are
// needed).
module ascii_radix_converter import arc_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] digit_char,
  input  logic [7:0] in_system,
  input  logic [7:0] out_system,
  input  logic       last_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       last_out,
  output logic       error
);

  state_t                 state;
  logic [VALUE_WIDTH-1:0] accum;
  logic                   dec_stopped;
  logic                   bad_digit;
  radix_t                 conv_radix;
  logic [IDX_W-1:0]       n;

  logic [VALUE_WIDTH-1:0] accum_next;
  logic                   dec_stopped_next;
  logic                   bad_digit_next;

  logic       out_free, accept, letters_ok, echo;
  logic       load_out, load_last, load_err;
  logic [7:0] load_char;

  logic                   div_start, div_busy, div_done;
  logic [VALUE_WIDTH-1:0] div_dividend, div_quo;
  logic [3:0]             div_rem, buf_rd;
  logic                   conv_stop;
  logic [IDX_W-1:0]       rd_idx;

  logic [3:0] dec_val, hex_val;
  logic       is_dec, is_hex;

  assign out_free   = !out_valid || !out_stall;
  assign in_stall   = (state != ST_IDLE) || !out_free;
  assign accept     = in_valid && !in_stall;
  assign letters_ok = letter_ok(in_system) && letter_ok(out_system);
  assign echo       = letters_ok && (in_system == out_system);

  always_comb begin
    is_dec  = (digit_char >= CH_ZERO) && (digit_char <= CH_NINE);
    dec_val = 4'(digit_char - CH_ZERO);
    is_hex  = 1'b1;
    hex_val = dec_val;
    if (!is_dec) begin
      if (digit_char >= CH_LC_A && digit_char <= CH_LC_F) begin
        hex_val = 4'(digit_char - CH_LC_A + 8'd10);
      end else if (digit_char >= CH_UC_A && digit_char <= CH_UC_F) begin
        hex_val = 4'(digit_char - CH_UC_A + 8'd10);
      end else begin
        is_hex = 1'b0;
      end
    end
  end

  always_comb begin
    accum_next       = accum;
    dec_stopped_next = dec_stopped;
    bad_digit_next   = bad_digit;
    case (to_radix(in_system))
      RADIX_BIN: begin
        accum_next = {accum[VALUE_WIDTH-2:0], digit_char == CH_ONE};
      end
      RADIX_DEC: begin
        if (!dec_stopped) begin
          if (is_dec) begin
            // x*10 = x*8 + x*2
            accum_next = (accum << 3) + (accum << 1)
                         + {{(VALUE_WIDTH-4){1'b0}}, dec_val};
          end else begin
            dec_stopped_next = 1'b1;
          end
        end
      end
      default: begin
        if (is_hex) begin
          accum_next = {accum[VALUE_WIDTH-5:0], hex_val};
        end else begin
          bad_digit_next = 1'b1;
        end
      end
    endcase
  end

  assign conv_stop = (div_quo == '0) || (n == IDX_W'(MAX_OUT - 1));

  // registered read: look one digit ahead when the current one leaves
  assign rd_idx = ((state == ST_EMIT) && out_free) ? n - IDX_W'(1) : n;

  always_comb begin
    load_out     = 1'b0;
    load_char    = 8'd0;
    load_last    = 1'b1;
    load_err     = 1'b1;
    div_start    = 1'b0;
    div_dividend = accum_next;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!letters_ok) begin
            load_out = last_char;
          end else if (echo) begin
            load_out  = 1'b1;
            load_char = digit_char;
            load_last = last_char;
            load_err  = 1'b0;
          end else if (last_char) begin
            load_out  = bad_digit_next;
            div_start = !bad_digit_next;
          end
        end
      end
      ST_DIV: begin
        div_dividend = div_quo;
        div_start    = div_done && !conv_stop;
      end
      ST_EMIT: begin
        load_out  = out_free;
        load_char = digit_ascii(buf_rd);
        load_last = (n == '0);
        load_err  = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      accum       <= '0;
      dec_stopped <= 1'b0;
      bad_digit   <= 1'b0;
      conv_radix  <= RADIX_BIN;
      n           <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && letters_ok && !echo) begin
            accum       <= accum_next;
            dec_stopped <= dec_stopped_next;
            bad_digit   <= bad_digit_next;
          end
          if (accept && last_char) begin
            accum       <= '0;
            dec_stopped <= 1'b0;
            bad_digit   <= 1'b0;
          end
          if (div_start) begin
            state      <= ST_DIV;
            conv_radix <= to_radix(out_system);
            n          <= '0;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            if (conv_stop) begin
              state <= ST_FETCH;
            end else begin
              n <= n + IDX_W'(1);
            end
          end
        end
        ST_FETCH: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            if (n == '0) begin
              state <= ST_IDLE;
            end else begin
              n <= n - IDX_W'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_char <= load_char;
      last_out <= load_last;
      error    <= load_err;
    end
  end

  arc_div_unit #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .radix    ((state == ST_IDLE) ? to_radix(out_system) : conv_radix),
    .dividend (div_dividend),
    .busy     (div_busy),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  arc_digit_buf #(
    .WIDTH(4),
    .DEPTH(MAX_OUT)
  ) u_buf (
    .clk     (clk),
    .wr_en   ((state == ST_DIV) && div_done),
    .wr_addr (n),
    .wr_data (div_rem),
    .rd_addr (rd_idx),
    .rd_data (buf_rd)
  );

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside conversion");

  a_dec_rem: assert property (@(posedge clk) disable iff (rst)
    (div_done && conv_radix == RADIX_DEC) |-> (div_rem <= 4'd9))
    else $error("decimal remainder out of range");

  a_emit_idle_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> !div_busy)
    else $error("divider busy while emitting");

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import arc_pkg::*;

  localparam int VW          = 32;
  localparam int QUIET_LIMIT = 4000;
  localparam int RANDOM_CHARS = 405;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
    logic       err;
  } emitted_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] digit_char = 8'h00;
  logic [7:0] in_system = 8'h00;
  logic [7:0] out_system = 8'h00;
  logic       last_char = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_char;
  logic       last_out;
  logic       error;

  // predictor state for the number in progress
  logic [VW-1:0] acc_val = '0;
  logic          dec_halted = 1'b0;
  logic          hex_bad = 1'b0;

  emitted_t due_chars[$];
  int       fail_count = 0;
  int       quiet_cycles = 0;
  int       chars_sent = 0;
  int       stall_left = 0;
  bit       gaps_on = 1'b0;
  bit       stall_on = 1'b0;

  ascii_radix_converter #(.VALUE_WIDTH(VW)) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .digit_char(digit_char),
    .in_system(in_system),
    .out_system(out_system),
    .last_char(last_char),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_char(out_char),
    .last_out(last_out),
    .error(error)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // mostly short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void clear_number();
    acc_val = '0;
    dec_halted = 1'b0;
    hex_bad = 1'b0;
  endfunction

  function automatic void add_expected(input logic [7:0] ch, input logic fin,
                                       input logic err);
    emitted_t e;
    e = '{ch, fin, err};
    due_chars = {due_chars, e};
  endfunction

  function automatic void convert_char(input logic [7:0] c, input logic [7:0] isys,
                                       input logic [7:0] osys, input logic lst);
    logic [VW-1:0] q;
    logic [VW-1:0] base;
    logic [3:0]    d;
    logic [3:0]    nib;
    logic          nib_ok;
    logic [7:0]    rev[$];
    if (!((isys == CH_B || isys == CH_D || isys == CH_H) &&
          (osys == CH_B || osys == CH_D || osys == CH_H))) begin
      if (lst) begin
        add_expected(8'h00, 1'b1, 1'b1);
        clear_number();
      end
      return;
    end
    if (isys == osys) begin
      add_expected(c, lst, 1'b0);
      if (lst) clear_number();
      return;
    end
    if (isys == CH_B) begin
      acc_val = {acc_val[VW-2:0], c == CH_ONE};
    end else if (isys == CH_D) begin
      if (!dec_halted) begin
        if (c >= CH_ZERO && c <= CH_NINE) acc_val = acc_val * 10 + (c - CH_ZERO);
        else dec_halted = 1'b1;
      end
    end else begin
      nib_ok = 1'b1;
      nib = '0;
      if (c >= CH_ZERO && c <= CH_NINE) nib = 4'(c - CH_ZERO);
      else if (c >= CH_LC_A && c <= CH_LC_F) nib = 4'(c - CH_LC_A + 8'd10);
      else if (c >= CH_UC_A && c <= CH_UC_F) nib = 4'(c - CH_UC_A + 8'd10);
      else nib_ok = 1'b0;
      if (nib_ok) acc_val = {acc_val[VW-5:0], nib};
      else hex_bad = 1'b1;
    end
    if (!lst) return;
    if (hex_bad) begin
      add_expected(8'h00, 1'b1, 1'b1);
      clear_number();
      return;
    end
    base = (osys == CH_B) ? 2 : (osys == CH_D) ? 10 : 16;
    q = acc_val;
    // digits come out least significant first; keep at most the low 32
    do begin
      d = 4'(q % base);
      rev.push_front(d < 4'd10 ? CH_ZERO + {4'b0, d} : CH_LC_A + {4'b0, d} - 8'd10);
      q = q / base;
    end while (q != 0 && rev.size() < MAX_OUT);
    foreach (rev[k]) add_expected(rev[k], k == rev.size() - 1, 1'b0);
    clear_number();
  endfunction

  // input side is predicted before output is checked, so ordering within the edge is fixed
  always @(posedge clk) begin
    emitted_t want;
    if (!rst) begin
      if (in_valid && !in_stall) convert_char(digit_char, in_system, out_system, last_char);
      if (out_valid && !out_stall) begin
        if (due_chars.size() == 0) begin
          $display("%0t: unexpected result: expected none, got char=%h last=%b err=%b",
                   $time, out_char, last_out, error);
          fail_count++;
        end else begin
          want = due_chars.pop_front();
          if (out_char !== want.ch) begin
            $display("%0t: out_char expected %h got %h", $time, want.ch, out_char);
            fail_count++;
          end
          if (last_out !== want.fin) begin
            $display("%0t: last_out expected %b got %b", $time, want.fin, last_out);
            fail_count++;
          end
          if (error !== want.err) begin
            $display("%0t: error expected %b got %b", $time, want.err, error);
            fail_count++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: timeout, nothing moved for %0d cycles", $time, QUIET_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left == 0 && stall_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // entered and left at a falling edge
  task automatic send_char(input logic [7:0] c, input logic [7:0] isys,
                           input logic [7:0] osys, input logic lst);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    digit_char <= c;
    in_system  <= isys;
    out_system <= osys;
    last_char  <= lst;
    in_valid   <= 1'b1;
    do @(posedge clk); while (in_stall);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input logic [7:0] isys, input logic [7:0] osys);
    for (int i = 0; i < s.len(); i++) send_char(s[i], isys, osys, i == s.len() - 1);
  endtask

  task automatic test_echo();
    send_char(8'h00, CH_B, CH_B, 1'b0);
    send_char(8'hff, CH_D, CH_D, 1'b0);
    send_char("z", CH_H, CH_H, 1'b1);
  endtask

  task automatic test_bad_letters();
    // not last: swallowed; last: single error item
    send_char("1", 8'hff, CH_D, 1'b0);
    send_char("7", CH_H, 8'h00, 1'b1);
  endtask

  task automatic test_binary();
    send_text("x1", CH_B, CH_D);
    send_text("0", CH_B, CH_H);
  endtask

  task automatic test_decimal();
    send_text("12a", CH_D, CH_H);
  endtask

  task automatic test_hex();
    send_text("fF", CH_H, CH_D);
    send_text("ffffffff", CH_H, CH_B);
    send_text("g", CH_H, CH_B);
  endtask

  function automatic logic [7:0] pick_letter();
    int r;
    r = $urandom_range(0, 2);
    return (r == 0) ? CH_B : (r == 1) ? CH_D : CH_H;
  endfunction

  function automatic logic [7:0] pick_digit(input logic [7:0] isys);
    int r;
    if ($urandom_range(0, 99) < 6) return 8'($urandom_range(0, 255));
    if (isys == CH_B) return $urandom_range(0, 1) ? CH_ONE : CH_ZERO;
    if (isys == CH_D) return CH_ZERO + 8'($urandom_range(0, 9));
    r = $urandom_range(0, 21);
    if (r < 10) return CH_ZERO + 8'(r);
    if (r < 16) return CH_LC_A + 8'(r - 10);
    return CH_UC_A + 8'(r - 16);
  endfunction

  task automatic send_random_number();
    logic [7:0] isys;
    logic [7:0] osys;
    logic [7:0] c;
    int kind;
    int len;
    int r;
    kind = $urandom_range(0, 99);
    r = $urandom_range(0, 99);
    len = (r < 80) ? $urandom_range(1, 10) : (r < 95) ? $urandom_range(11, 20) :
          $urandom_range(21, 40);
    isys = pick_letter();
    osys = pick_letter();
    if (kind < 70) begin
      while (osys == isys) osys = pick_letter();
    end else if (kind < 82) begin
      osys = isys;
    end
    for (int i = 0; i < len; i++) begin
      if (kind >= 92) begin
        // letters change from character to character
        isys = pick_letter();
        osys = pick_letter();
      end
      c = (isys == osys) ? 8'($urandom_range(0, 255)) : pick_digit(isys);
      if (kind >= 82 && kind < 92) begin
        if ($urandom_range(0, 1)) send_char(c, 8'($urandom_range(0, 255)), osys, i == len - 1);
        else send_char(c, isys, 8'($urandom_range(0, 255)), i == len - 1);
      end else begin
        send_char(c, isys, osys, i == len - 1);
      end
    end
  endtask

  task automatic test_random();
    int start;
    int phase;
    start = chars_sent;
    while (chars_sent - start < RANDOM_CHARS) begin
      phase = ((chars_sent - start) / 60) % 4;
      gaps_on  = phase[0];
      stall_on = phase[1] | (phase == 0 && chars_sent - start > 200);
      send_random_number();
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    gaps_on  = 1'b1;
    stall_on = 1'b1;
    test_echo();
    test_bad_letters();
    test_binary();
    test_decimal();
    test_hex();
    test_random();
    in_valid <= 1'b0;
    while (due_chars.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
